### rtl/core/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fsps_pkg.sv
// Shared types and constants for the tick scheduler.
// Used by the register block, the controller, the datapath and the top level.
package fsps_pkg;

   localparam int SLOT_W       = 4;
   localparam int ARR_W        = 16;
   localparam int RUN_W        = 16;
   localparam int TICK_W       = 16;
   localparam int POLICY_W     = 2;
   localparam int JOBS_W       = 5;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_SJF  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_PSJF = 2'd2;

   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_JOBS   = 1'b1;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_FIFO;
   localparam logic [JOBS_W-1:0]   JOBS_RESET   = 5'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REL_RD,
      ST_REL_CHK,
      ST_CUR_CHK,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic rel_inc;
      logic cur_check;
      logic scan_step;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rel_more;
      logic rel_hit;
      logic keep_cur;
      logic scan_done;
      logic out_busy;
   } dp_status_type;

endpackage

### rtl/core/fsps_csr.sv
// Configuration registers of the tick scheduler behind a simple APB-style port.
// Depends on fsps_pkg for widths and register indexes.
module fsps_csr
   import fsps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [POLICY_W-1:0]   sched_policy,
   output logic [JOBS_W-1:0]     job_count
);

   logic                wr_en;
   logic                reg_idx;
   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [JOBS_W-1:0]   jobs_ff, jobs_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // word aligned map: the low address bits are not decoded
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      policy_in = policy_ff;
      jobs_in   = jobs_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_POLICY: policy_in = csr_pwdata[POLICY_W-1:0];
            REG_JOBS:   jobs_in   = csr_pwdata[JOBS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         jobs_ff   <= JOBS_RESET;
      end else begin
         policy_ff <= policy_in;
         jobs_ff   <= jobs_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_POLICY: csr_prdata = CSR_DATA_W'(policy_ff);
         REG_JOBS:   csr_prdata = CSR_DATA_W'(jobs_ff);
      endcase
   end

   assign sched_policy = policy_ff;
   assign job_count    = jobs_ff;

endmodule

### rtl/core/fsps_ctrl.sv
// Sequencing state machine for the tick scheduler: release, select, update.
// Depends on fsps_pkg for the state, command and status types.
module fsps_ctrl
   import fsps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_action,
   output logic          req_tready,
   input  dp_status_type st,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_action == ACTION_TICK)) state_in = ST_REL_RD;
         end
         ST_REL_RD: begin
            state_in = st.rel_more ? ST_REL_CHK : ST_CUR_CHK;
         end
         ST_REL_CHK: begin
            state_in = st.rel_hit ? ST_REL_RD : ST_CUR_CHK;
         end
         ST_CUR_CHK: begin
            state_in = st.keep_cur ? ST_UPDATE : ST_SCAN;
         end
         ST_SCAN: begin
            if (st.scan_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!st.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid && (req_action == ACTION_LOAD);
         end
         ST_REL_RD: begin
         end
         ST_REL_CHK: begin
            cmd.rel_inc = st.rel_hit;
         end
         ST_CUR_CHK: begin
            cmd.cur_check = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = !st.out_busy;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/fsps_dp.sv
// Datapath of the tick scheduler: job tables, release and selection counters,
// time counter and the result register. Depends on fsps_pkg.
module fsps_dp
   import fsps_pkg::*;
#(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         st,
   input  logic [SLOT_W-1:0]     load_slot,
   input  logic [ARR_W-1:0]      load_arrival,
   input  logic [RUN_W-1:0]      load_run,
   input  logic [POLICY_W-1:0]   sched_policy,
   input  logic [JOBS_W-1:0]     job_count,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;
   localparam int ALL_W = (CNT_W > JOBS_W) ? CNT_W : JOBS_W;

   logic [ARR_W-1:0] arr_mem [MAX_JOBS];
   logic [RUN_W-1:0] rem_mem [MAX_JOBS];

   logic [ARR_W-1:0]      arr_rd_ff;
   logic [RUN_W-1:0]      rem_rd_ff;
   logic [CNT_W-1:0]      rel_cnt_ff, rel_cnt_in;
   logic [IDX_W-1:0]      cur_slot_ff, cur_slot_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [CNT_W-1:0]      done_cnt_ff, done_cnt_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [RUN_W-1:0]      best_rem_ff, best_rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] jobs;
   logic [CNT_W-1:0] elig_n;
   logic             load_ok;
   logic [IDX_W-1:0] load_addr;
   logic [IDX_W-1:0] arr_addr;
   logic [IDX_W-1:0] rem_addr;
   logic             scan_issue;
   logic             shortest;
   logic             preempt;
   logic             take;
   logic [RUN_W-1:0] rem_dec;
   logic             fin;
   logic             sw;
   logic [CNT_W-1:0] done_next;
   logic             all_done;
   logic [CMP_W-1:0] time_x;

   assign jobs   = (32'(job_count) > 32'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : CNT_W'(job_count);
   assign elig_n = (rel_cnt_ff < jobs) ? rel_cnt_ff : jobs;

   assign load_ok   = 32'(load_slot) < 32'(MAX_JOBS);
   assign load_addr = IDX_W'(load_slot);

   assign time_x     = CMP_W'(time_ff);
   assign scan_issue = scan_idx_ff < elig_n;
   assign shortest   = (sched_policy == POLICY_SJF) || (sched_policy == POLICY_PSJF);
   assign preempt    = (sched_policy == POLICY_PSJF);

   assign arr_addr = (rel_cnt_ff < jobs) ? rel_cnt_ff[IDX_W-1:0] : '0;
   // outside the scan the remaining-time port keeps reading the current slot,
   // so its value is fresh by the time the tick reaches the current-job check
   assign rem_addr = cmd.scan_step ? (scan_issue ? scan_idx_ff[IDX_W-1:0] : '0)
                                   : cur_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         arr_mem[load_addr] <= load_arrival;
      end
      arr_rd_ff <= arr_mem[arr_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         rem_mem[load_addr] <= load_run;
      end else if (cmd.update && found_ff) begin
         rem_mem[best_idx_ff] <= rem_dec;
      end
      rem_rd_ff <= rem_mem[rem_addr];
   end

   assign st.rel_more  = rel_cnt_ff < jobs;
   assign st.rel_hit   = CMP_W'(arr_rd_ff) <= time_x;
   assign st.keep_cur  = cur_valid_ff && (rem_rd_ff != '0) && !preempt;
   assign st.scan_done = !scan_issue && !cmp_valid_ff;
   assign st.out_busy  = rsp_valid_ff && !rsp_tready;

   assign take = cmp_valid_ff && (rem_rd_ff != '0) &&
                 (!found_ff || (shortest && (rem_rd_ff < best_rem_ff)));

   assign rem_dec   = best_rem_ff - RUN_W'(1);
   assign fin       = found_ff && (best_rem_ff == RUN_W'(1));
   assign sw        = found_ff && cur_valid_ff && (best_idx_ff != cur_slot_ff);
   assign done_next = (fin && (done_cnt_ff < CNT_W'(MAX_JOBS))) ? done_cnt_ff + CNT_W'(1)
                                                               : done_cnt_ff;
   assign all_done  = ALL_W'(done_next) >= ALL_W'(job_count);

   always_comb begin
      rel_cnt_in   = rel_cnt_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      done_cnt_in  = done_cnt_ff;
      time_in      = time_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.rel_inc) begin
         rel_cnt_in = rel_cnt_ff + CNT_W'(1);
      end

      if (cmd.cur_check) begin
         // drop a current job whose slot was reloaded with nothing left
         if (cur_valid_ff && (rem_rd_ff == '0)) cur_valid_in = 1'b0;
         if (st.keep_cur) begin
            found_in    = 1'b1;
            best_idx_in = cur_slot_ff;
            best_rem_in = rem_rd_ff;
         end else begin
            found_in     = 1'b0;
            scan_idx_in  = '0;
            cmp_valid_in = 1'b0;
         end
      end

      if (cmd.scan_step) begin
         cmp_valid_in = scan_issue;
         cmp_idx_in   = rem_addr;
         if (scan_issue) scan_idx_in = scan_idx_ff + CNT_W'(1);
         if (take) begin
            found_in    = 1'b1;
            best_idx_in = cmp_idx_ff;
            best_rem_in = rem_rd_ff;
         end
      end

      if (cmd.update) begin
         if (found_ff) begin
            cur_slot_in  = best_idx_ff;
            cur_valid_in = !fin;
         end
         done_cnt_in  = done_next;
         time_in      = (time_ff == {TIME_BITS{1'b1}}) ? time_ff : time_ff + TIME_BITS'(1);
         rsp_valid_in = 1'b1;
         rsp_data_in  = {time_x[TICK_W-1:0], all_done, fin, sw, found_ff,
                         found_ff ? SLOT_W'(best_idx_ff) : SLOT_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_cnt_ff   <= '0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         done_cnt_ff  <= '0;
         time_ff      <= '0;
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rel_cnt_ff   <= rel_cnt_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         done_cnt_ff  <= done_cnt_in;
         time_ff      <= time_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/fifo_sjf_psjf_tick_scheduler.sv
// Tick-driven job scheduler with FIFO, non-preemptive SJF and preemptive SJF
// policies. A load transaction (tuser 0) writes one job slot. A tick transaction
// (tuser 1) releases arrived jobs, picks the job to run, takes one unit off its
// remaining time and returns one result transaction. Each job table has a single
// read port, which the release pass walks slot by slot and the selection scan reads
// one released slot per cycle; when any policy but PSJF keeps the running job the
// scan is skipped. One tick is in work at a time; a finished result waits in the
// output register while loads are taken.
// Files: fsps_pkg, fsps_csr, fsps_ctrl, fsps_dp, assert_macros.svh.
`include "assert_macros.svh"

module fifo_sjf_psjf_tick_scheduler
   import fsps_pkg::*;
#(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] slot, [19:4] arrival_time, [35:20] run_length, [39:36] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] running_slot, [4] running_valid, [5] switched, [6] finished,
   // [7] all_done, [23:8] tick_time
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [POLICY_W-1:0] sched_policy;
   logic [JOBS_W-1:0]   job_count;
   ctrl_cmd_type        cmd;
   dp_status_type       st;

   fsps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .sched_policy (sched_policy),
      .job_count    (job_count)
   );

   fsps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fsps_dp #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .load_slot    (req_tdata[3:0]),
      .load_arrival (req_tdata[19:4]),
      .load_run     (req_tdata[35:20]),
      .sched_policy (sched_policy),
      .job_count    (job_count),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   `ASSERT_SAME(a_no_overwrite, clock, reset, cmd.update, !st.out_busy, "result overwritten while waiting")
   `ASSERT_SAME(a_fin_ran, clock, reset, rsp_tvalid && (rsp_tdata[6] || rsp_tdata[5]), rsp_tdata[4], "finish or switch flagged with no job run")
   `ASSERT_NEXT(a_tick_busy, clock, reset, req_tvalid && req_tready && (req_tuser == ACTION_TICK), !req_tready, "tick accepted but block still ready")

endmodule

### dv/tb_fifo_sjf_psjf_tick_scheduler.sv
// Self-checking testbench for the FIFO / SJF / PSJF tick scheduler.
// Drives load and tick transactions under every policy and predicts each tick result.
// Depends on fsps_pkg and the fifo_sjf_psjf_tick_scheduler RTL only.
module tb_fifo_sjf_psjf_tick_scheduler
   import fsps_pkg::*;
;

   localparam int NUM_SLOTS     = 16;
   localparam int TIME_CEIL     = 65535;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_ITEMS   = 50;

   localparam logic [POLICY_W-1:0]   POLICY_SPARE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_POLICY  = CSR_ADDR_W'(int'(REG_POLICY) * 4);
   localparam logic [CSR_ADDR_W-1:0] ADDR_JOBS    = CSR_ADDR_W'(int'(REG_JOBS) * 4);

   // Packed so that running_slot lands in the low bits of rsp_tdata.
   typedef struct packed {
      logic [TICK_W-1:0] tick_time;
      logic              all_done;
      logic              finished;
      logic              switched;
      logic              running_valid;
      logic [SLOT_W-1:0] running_slot;
   } tick_result_type;

   class tick_board_type;
      logic [ARR_W-1:0]    arrival [NUM_SLOTS];
      logic [RUN_W-1:0]    remaining [NUM_SLOTS];
      int unsigned         released_count;
      int unsigned         current_slot;
      bit                  current_valid;
      int unsigned         done_count;
      int unsigned         time_now;
      logic [POLICY_W-1:0] policy;
      logic [JOBS_W-1:0]   job_count;
      tick_result_type     expected_ticks[$];
      int                  failures;

      function new();
         foreach (arrival[i]) begin
            arrival[i]   = '0;
            remaining[i] = '0;
         end
         released_count = 0;
         current_slot   = 0;
         current_valid  = 0;
         done_count     = 0;
         time_now       = 0;
         policy         = POLICY_RESET;
         job_count      = JOBS_RESET;
         failures       = 0;
      endfunction

      function int pending();
         return expected_ticks.size();
      endfunction

      // Lowest slot with time left, or the shortest one when by_length is set.
      function bit find_job(int unsigned n, bit by_length, output int unsigned pick);
         bit found;
         found = 0;
         pick  = 0;
         for (int unsigned i = 0; i < n; i++) begin
            if (remaining[i] == 0) continue;
            if (!by_length) begin
               pick = i;
               return 1;
            end
            if (!found || remaining[i] < remaining[pick]) begin
               pick  = i;
               found = 1;
            end
         end
         return found;
      endfunction

      function void accept_item(logic action, logic [SLOT_W-1:0] slot,
                                logic [ARR_W-1:0] arr, logic [RUN_W-1:0] run);
         int unsigned     jobs;
         int unsigned     n;
         int unsigned     pick;
         bit              have;
         tick_result_type res;
         if (action == ACTION_LOAD) begin
            arrival[slot]   = arr;
            remaining[slot] = run;
            return;
         end
         res  = '0;
         jobs = (job_count > NUM_SLOTS) ? NUM_SLOTS : job_count;
         while (released_count < jobs && arrival[released_count] <= time_now)
            released_count++;
         n = (released_count < jobs) ? released_count : jobs;
         // drop a current job that was reloaded with nothing left
         if (current_valid && remaining[current_slot] == 0)
            current_valid = 0;
         if (policy == POLICY_PSJF)
            have = find_job(n, 1'b1, pick);
         else if (current_valid) begin
            have = 1;
            pick = current_slot;
         end else if (policy == POLICY_SJF)
            have = find_job(n, 1'b1, pick);
         else
            have = find_job(n, 1'b0, pick);
         if (have) begin
            res.switched      = current_valid && pick != current_slot;
            current_slot      = pick;
            current_valid     = 1;
            res.running_valid = 1'b1;
            res.running_slot  = SLOT_W'(pick);
            remaining[pick]   = remaining[pick] - 1'b1;
            if (remaining[pick] == 0) begin
               res.finished  = 1'b1;
               current_valid = 0;
               if (done_count < NUM_SLOTS) done_count++;
            end
         end
         res.all_done  = done_count >= job_count;
         res.tick_time = TICK_W'(time_now);
         if (time_now < TIME_CEIL) time_now++;
         expected_ticks.push_back(res);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void compare_tick(logic [RSP_DATA_W-1:0] data);
         tick_result_type got;
         tick_result_type want;
         got = tick_result_type'(data);
         if (expected_ticks.size() == 0) begin
            $error("result transaction with no tick pending: 0x%06h", data);
            failures++;
            return;
         end
         want = expected_ticks.pop_front();
         compare_field("running_slot", 32'(want.running_slot), 32'(got.running_slot));
         compare_field("running_valid", 32'(want.running_valid), 32'(got.running_valid));
         compare_field("switched", 32'(want.switched), 32'(got.switched));
         compare_field("finished", 32'(want.finished), 32'(got.finished));
         compare_field("all_done", 32'(want.all_done), 32'(got.all_done));
         compare_field("tick_time", 32'(want.tick_time), 32'(got.tick_time));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = ACTION_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tick_board_type board = new();
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int unsigned    cycle_count = 0;

   fifo_sjf_psjf_tick_scheduler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.compare_tick(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [POLICY_W-1:0] policy, logic [JOBS_W-1:0] jobs);
      write_csr(ADDR_POLICY, CSR_DATA_W'(policy));
      board.policy = policy;
      write_csr(ADDR_JOBS, CSR_DATA_W'(jobs));
      board.job_count = jobs;
   endtask

   task automatic send_item(logic action, logic [SLOT_W-1:0] slot,
                            logic [ARR_W-1:0] arr, logic [RUN_W-1:0] run);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0000, run, arr, slot};
      do @(posedge clock); while (!req_tready);
      board.accept_item(action, slot, arr, run);
   endtask

   task automatic send_tick();
      send_item(ACTION_TICK, SLOT_W'($urandom), ARR_W'($urandom), RUN_W'($urandom));
   endtask

   task automatic send_random_item();
      logic [SLOT_W-1:0] slot;
      logic [ARR_W-1:0]  arr;
      logic [RUN_W-1:0]  run;
      int                roll;
      if ($urandom_range(0, 99) < 55) begin
         send_tick();
         return;
      end
      slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 5)
         run = '0;
      else if (roll < 85)
         run = RUN_W'($urandom_range(1, 6));
      else
         run = RUN_W'($urandom_range(1, 65535));
      // keep unreleased slots close to the clock so release keeps moving
      if (slot < board.released_count && $urandom_range(0, 1))
         arr = ARR_W'($urandom_range(0, 65535));
      else if (board.time_now + 4 > TIME_CEIL)
         arr = ARR_W'(TIME_CEIL);
      else
         arr = ARR_W'(board.time_now + $urandom_range(0, 4));
      send_item(ACTION_LOAD, slot, arr, run);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [POLICY_W-1:0] policy, logic [JOBS_W-1:0] jobs,
                            int send_pct, int recv_pct);
      settle();
      configure(policy, jobs);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         // hold the sender until every tick result is back
         if (k == PHASE_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
         end
         send_random_item();
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("fifo_sjf_psjf_tick_scheduler regression: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 16;
      recv_idle_pct = 51;
      configure(POLICY_FIFO, 5'd4);
      // load every slot before the first tick; slot 3 carries no work
      for (int i = 0; i < NUM_SLOTS; i++)
         send_item(ACTION_LOAD, SLOT_W'(i),
                   (i == NUM_SLOTS - 1) ? ARR_W'(TIME_CEIL) : ARR_W'(i),
                   (i == 3) ? RUN_W'(0) :
                   (i == NUM_SLOTS - 1) ? RUN_W'(65535) : RUN_W'(1 + i % 3));
      repeat (4) send_tick();
      // overwrite the running job with nothing left
      send_item(ACTION_LOAD, SLOT_W'(board.current_slot), ARR_W'(board.time_now), '0);
      repeat (3) send_tick();

      run_phase(POLICY_FIFO,  5'd16, 16, 51);
      run_phase(POLICY_SJF,   5'd16, 16, 51);
      run_phase(POLICY_PSJF,  5'd16, 16, 51);
      run_phase(POLICY_SPARE, 5'd8,  51, 16);
      run_phase(POLICY_PSJF,  5'd0,  51, 16);
      run_phase(POLICY_SJF,   5'd20, 51, 16);
      run_phase(POLICY_FIFO,  5'd1,  0,  0);
      run_phase(POLICY_PSJF,  5'd31, 0,  0);
      settle();

      if (board.failures == 0)
         $display("fifo_sjf_psjf_tick_scheduler regression: pass");
      else
         $display("fifo_sjf_psjf_tick_scheduler regression: fail");
      $finish;
   end

endmodule
